[rtl/cfe_pkg.sv]
`default_nettype none
package cfe_pkg;

	localparam int FIELD_LIMIT  = 256;
	localparam int VALUE_LIMIT  = 4096;
	localparam int RECORD_LIMIT = 65536;

	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 3;
	localparam int LEN_W    = 13;
	localparam int RECNO_W  = 16;
	localparam int TFIELD_W = 8;
	localparam int FCOUNT_W = 9;
	localparam int RCOUNT_W = 17;
	localparam int MAXLEN_W = 13;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_BYTE     = 3'd0;
	localparam status_t ST_DONE     = 3'd1;
	localparam status_t ST_NOTFOUND = 3'd2;
	localparam status_t ST_TOOLONG  = 3'd3;
	localparam status_t ST_RANGE    = 3'd4;

	typedef enum logic [1:0] {
		REG_TARGET_FIELD = 2'd0,
		REG_FLD_CNT      = 2'd1,
		REG_REC_CNT      = 2'd2,
		REG_MAX_LENGTH   = 2'd3
	} reg_idx_t;

	localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST = 13'd4096;

	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

endpackage
`default_nettype wire

[rtl/cfe_in_if.sv]
`default_nettype none
interface cfe_in_if;
	import cfe_pkg::*;

	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  data_byte;
	logic               first_of_record;
	logic               end_of_data;
	logic [RECNO_W-1:0] record_number;

	modport source (output valid, data_byte, first_of_record, end_of_data, record_number,
		input ready);
	modport sink (input valid, data_byte, first_of_record, end_of_data, record_number,
		output ready);
endinterface
`default_nettype wire

[rtl/cfe_out_if.sv]
`default_nettype none
interface cfe_out_if;
	import cfe_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] value_byte;
	status_t           status;
	logic [LEN_W-1:0]  value_length;
	logic              is_last;

	modport source (output valid, value_byte, status, value_length, is_last, input ready);
	modport sink (input valid, value_byte, status, value_length, is_last, output ready);
endinterface
`default_nettype wire

[rtl/csv_field_extractor.sv]
`default_nettype none
// Channel   | Dir | Beat
// ----------+-----+--------------------------------------------------------------
// record    | in  | data_byte, first_of_record, end_of_data, record_number
// result    | out | value_byte, status, value_length, is_last (zero or one per beat)
// APB       | in  | target field, field and record counts, max length at 0x0..0xC
//
// One input beat per cycle while the output register is not stalled. A beat is
// captured in the _s1 register and parsed against the field/quote/length state;
// a result lands in the output register when the parse stage fires.
// arst_n resets all control state; max_length resets to 4096, other regs to 0.
// A stalled output register holds the parse stage; the input register still
// refills in the cycle the output beat is taken.
module csv_field_extractor (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	cfe_in_if.sink                             record,
	cfe_out_if.source                          result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cfe_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [cfe_pkg::PDATA_W-1:0]   pwdata,
	output logic      [cfe_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready
);
	import cfe_pkg::*;

	// configuration
	logic [TFIELD_W-1:0] target_field_q;
	logic [FCOUNT_W-1:0] fld_cnt_q;
	logic [RCOUNT_W-1:0] rec_cnt_q;
	logic [MAXLEN_W-1:0] max_length_q;
	reg_idx_t            reg_idx;
	logic                wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_field_q <= '0;
			fld_cnt_q      <= '0;
			rec_cnt_q      <= '0;
			max_length_q   <= MAX_LENGTH_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TARGET_FIELD: target_field_q <= pwdata[TFIELD_W-1:0];
				REG_FLD_CNT:      fld_cnt_q      <= pwdata[FCOUNT_W-1:0];
				REG_REC_CNT:      rec_cnt_q      <= pwdata[RCOUNT_W-1:0];
				REG_MAX_LENGTH:   max_length_q   <= pwdata[MAXLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TARGET_FIELD: prdata = PDATA_W'(target_field_q);
			REG_FLD_CNT:      prdata = PDATA_W'(fld_cnt_q);
			REG_REC_CNT:      prdata = PDATA_W'(rec_cnt_q);
			REG_MAX_LENGTH:   prdata = PDATA_W'(max_length_q);
			default:          prdata = '0;
		endcase
	end

	// effective limits
	logic [31:0] rc_eff, fc_eff, ml_eff;
	always_comb begin
		rc_eff = (32'(rec_cnt_q) < 32'(RECORD_LIMIT)) ? 32'(rec_cnt_q)
			: 32'(RECORD_LIMIT);
		fc_eff = (32'(fld_cnt_q) < 32'(FIELD_LIMIT)) ? 32'(fld_cnt_q)
			: 32'(FIELD_LIMIT);
		ml_eff = (32'(max_length_q) < 32'(VALUE_LIMIT)) ? 32'(max_length_q)
			: 32'(VALUE_LIMIT);
	end

	// input register
	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                first_s1;
	logic                eod_s1;
	logic [RECNO_W-1:0]  recno_s1;
	logic                fire_s1;
	logic                out_valid_q;

	assign fire_s1      = valid_s1 && (!out_valid_q || result.ready);
	assign record.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (record.ready) begin
			valid_s1 <= record.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (record.ready && record.valid) begin
			byte_s1  <= record.data_byte;
			first_s1 <= record.first_of_record;
			eod_s1   <= record.end_of_data;
			recno_s1 <= record.record_number;
		end
	end

	// parse state
	logic [TFIELD_W-1:0] field_q;
	logic [LEN_W-1:0]    copied_q;
	logic                quoted_q;
	logic                finished_q;

	logic [TFIELD_W-1:0] field_n;
	logic [LEN_W-1:0]    copied_n;
	logic                quoted_n;
	logic                finished_n;
	logic [LEN_W:0]      copied_inc;
	logic                res_v;
	logic [BYTE_W-1:0]   res_byte;
	status_t             res_status;
	logic [LEN_W-1:0]    res_len;
	logic                range_bad;
	logic                terminator;

	always_comb begin
		field_n    = field_q;
		copied_n   = copied_q;
		quoted_n   = quoted_q;
		finished_n = finished_q;
		res_v      = 1'b0;
		res_byte   = '0;
		res_status = ST_BYTE;
		res_len    = '0;
		copied_inc = {1'b0, copied_q} + 1'b1;
		range_bad  = (32'(recno_s1) >= rc_eff) || (32'(target_field_q) >= fc_eff);
		terminator = (byte_s1 == CH_QUOTE) || (!quoted_q &&
			((byte_s1 == CH_COMMA) || (byte_s1 == CH_LF) || (byte_s1 == CH_CR)));

		if (first_s1) begin
			field_n    = '0;
			copied_n   = '0;
			quoted_n   = 1'b0;
			finished_n = 1'b0;
			copied_inc = {{LEN_W{1'b0}}, 1'b1};
			terminator = (byte_s1 == CH_QUOTE) || (byte_s1 == CH_COMMA) ||
				(byte_s1 == CH_LF) || (byte_s1 == CH_CR);
		end

		if (first_s1 && range_bad) begin
			res_v      = 1'b1;
			res_status = ST_RANGE;
		end else if (!finished_n) begin
			if (eod_s1) begin
				res_v = 1'b1;
				if (field_n == target_field_q) begin
					res_status = ST_DONE;
					res_len    = copied_n;
				end else begin
					res_status = ST_NOTFOUND;
				end
			end else if ((copied_n == '0) && (byte_s1 == CH_QUOTE)) begin
				quoted_n = !quoted_n;
			end else if (field_n == target_field_q) begin
				res_v = 1'b1;
				if (terminator) begin
					res_status = ST_DONE;
					res_len    = copied_n;
				end else begin
					copied_n = copied_inc[LEN_W-1:0];
					if (32'(copied_inc) > ml_eff) begin
						res_status = ST_TOOLONG;
					end else begin
						res_byte = byte_s1;
					end
				end
			end else begin
				// advance field count on an unquoted separator
				if (!quoted_n && (byte_s1 == CH_COMMA)) begin
					field_n = field_n + 1'b1;
				end
				if (byte_s1 == CH_LF) begin
					res_v      = 1'b1;
					res_status = ST_NOTFOUND;
				end
			end
		end

		if (res_v && (res_status != ST_BYTE)) begin
			finished_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q    <= '0;
			copied_q   <= '0;
			quoted_q   <= 1'b0;
			finished_q <= 1'b1;
		end else if (fire_s1) begin
			field_q    <= field_n;
			copied_q   <= copied_n;
			quoted_q   <= quoted_n;
			finished_q <= finished_n;
		end
	end

	// output register
	logic              out_load;
	logic [BYTE_W-1:0] out_byte_q;
	status_t           out_status_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_last_q;

	assign out_load = fire_s1 && res_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q   <= res_byte;
			out_status_q <= res_status;
			out_len_q    <= res_len;
			out_last_q   <= (res_status != ST_BYTE);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.value_byte   = out_byte_q;
	assign result.status       = out_status_q;
	assign result.value_length = out_len_q;
	assign result.is_last      = out_last_q;

`ifndef SYNTHESIS
	a_last_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_last_q == (out_status_q != ST_BYTE)))
		else $error("is_last disagrees with status");

	a_finish_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(finished_q) |-> $past(out_load && (res_status != ST_BYTE)))
		else $error("extraction finished without a closing result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !out_load)
		else $error("pending result overwritten");

	a_length_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != ST_DONE)) |-> (out_len_q == '0))
		else $error("length reported outside a completed value");
`endif
endmodule
`default_nettype wire
